/* rtl/vtp_pkg.sv */
`timescale 1ns / 1ps
package vtp_pkg;
  localparam int CoordW = 16;
  localparam int RowW   = 64;
  localparam int AccW   = 32;
  localparam int QuoW   = 17;
  localparam int DivSteps = QuoW;
  localparam int MulLat = 2;
  localparam int DivLat = DivSteps + 2;
  localparam int Latency = MulLat + DivLat;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t RegRow0 = 2'd0;
  localparam reg_idx_t RegRow1 = 2'd1;
  localparam reg_idx_t RegRow2 = 2'd2;
  localparam reg_idx_t RegRow3 = 2'd3;

  localparam logic [RowW-1:0] Row3Reset = 64'd256;

  function automatic coord_t coef(input logic [RowW-1:0] row, input logic [1:0] col);
    coef = coord_t'(row[(3 - col) * CoordW +: CoordW]);
  endfunction
endpackage

/* rtl/vtp_in_if.sv */
`timescale 1ns / 1ps
interface vtp_in_if;
  import vtp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  coord_t vertex_z;
  modport source(output valid, output vertex_x, output vertex_y, output vertex_z, input ready);
  modport sink(input valid, input vertex_x, input vertex_y, input vertex_z, output ready);
endinterface

/* rtl/vtp_out_if.sv */
`timescale 1ns / 1ps
interface vtp_out_if;
  import vtp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t screen_x;
  coord_t screen_y;
  logic   w_zero;
  modport source(output valid, output screen_x, output screen_y, output w_zero, input ready);
  modport sink(input valid, input screen_x, input screen_y, input w_zero, output ready);
endinterface

/* rtl/vtp_mult.sv */
`timescale 1ns / 1ps
module vtp_mult (
  input  logic                     clk,
  input  logic                     en,
  input  logic [vtp_pkg::RowW-1:0] row0,
  input  logic [vtp_pkg::RowW-1:0] row1,
  input  logic [vtp_pkg::RowW-1:0] row3,
  input  vtp_pkg::coord_t          vx,
  input  vtp_pkg::coord_t          vy,
  input  vtp_pkg::coord_t          vz,
  output vtp_pkg::acc_t            tx,
  output vtp_pkg::acc_t            ty,
  output vtp_pkg::acc_t            tw
);
  import vtp_pkg::*;

  acc_t prod [3][4];
  logic [RowW-1:0] rows [3];
  coord_t comp [3];

  assign rows[0] = row0;
  assign rows[1] = row1;
  assign rows[2] = row3;
  assign comp[0] = vx;
  assign comp[1] = vy;
  assign comp[2] = vz;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= acc_t'(coef(rows[r], 2'(c))) * acc_t'(comp[c]);
        end
        // w component is 1.0 in Q8.8
        prod[r][3] <= acc_t'(coef(rows[r], 2'd3)) <<< 8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx <= prod[0][0] + prod[0][1] + prod[0][2] + prod[0][3];
      ty <= prod[1][0] + prod[1][1] + prod[1][2] + prod[1][3];
      tw <= prod[2][0] + prod[2][1] + prod[2][2] + prod[2][3];
    end
  end
endmodule

/* rtl/vtp_div.sv */
`timescale 1ns / 1ps
module vtp_div (
  input  logic            clk,
  input  logic            en,
  input  vtp_pkg::acc_t   num,
  input  vtp_pkg::acc_t   den,
  output vtp_pkg::coord_t quo
);
  import vtp_pkg::*;

  localparam int WideW = AccW + QuoW;

  logic [AccW-1:0] rem [DivSteps+1];
  logic [AccW-1:0] dmag [DivSteps+1];
  logic [QuoW-1:0] qb [DivSteps+1];
  logic            neg [DivSteps+1];
  logic            ovf [DivSteps+1];

  logic [AccW-1:0] an;
  logic [AccW-1:0] ad;

  assign an = num[AccW-1] ? AccW'(-num) : AccW'(num);
  assign ad = den[AccW-1] ? AccW'(-den) : AccW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= an;
      dmag[0] <= ad;
      qb[0]   <= '0;
      neg[0]  <= num[AccW-1] ^ den[AccW-1];
      ovf[0]  <= {{QuoW{1'b0}}, an} >= {ad, {QuoW{1'b0}}};
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    localparam int Bit = DivSteps - 1 - k;
    logic [WideW-1:0] dsh;
    logic             ge;
    assign dsh = {{QuoW{1'b0}}, dmag[k]} << Bit;
    assign ge  = {{QuoW{1'b0}}, rem[k]} >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]     <= ge ? rem[k] - dsh[AccW-1:0] : rem[k];
        qb[k+1]      <= qb[k] | (ge ? QuoW'(1) << Bit : '0);
        dmag[k+1]    <= dmag[k];
        neg[k+1]     <= neg[k];
        ovf[k+1]     <= ovf[k];
      end
    end
  end

  logic [QuoW-1:0] mag;
  assign mag = qb[DivSteps];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[DivSteps]) begin
        if (ovf[DivSteps] || mag > QuoW'(32768)) quo <= coord_t'(16'h8000);
        else quo <= coord_t'(-mag);
      end else begin
        if (ovf[DivSteps] || mag > QuoW'(32767)) quo <= coord_t'(16'h7fff);
        else quo <= coord_t'(mag);
      end
    end
  end
endmodule

/* rtl/vertex_transform_perspective_divide.sv */
`timescale 1ns / 1ps
// channel | dir | fields                         | handshake
// vertex  | in  | vertex_x, vertex_y, vertex_z   | valid/ready
// screen  | out | screen_x, screen_y, w_zero     | valid/ready
// cfg     | in  | cfg_index, cfg_data            | cfg_we
// One vertex per cycle while the output is not stalled; products, then sums, then the
// radix-2 divider (magnitude setup, 17 quotient bits, sign and saturation).
// Synchronous reset clears the valid chain and loads the reset matrix.
// A stalled output freezes the whole pipeline; vertex.ready = !screen.valid || screen.ready.
module vertex_transform_perspective_divide (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  vtp_pkg::reg_idx_t        cfg_index,
  input  logic [vtp_pkg::RowW-1:0] cfg_data,
  vtp_in_if.sink                   vertex,
  vtp_out_if.source                screen
);
  import vtp_pkg::*;

  logic [RowW-1:0] row0, row1, row2, row3;
  logic [Latency-1:0] vld;
  logic [DivLat-1:0]  wz;
  logic en;
  acc_t tx, ty, tw;

  assign en = !vld[Latency-1] || screen.ready;
  assign vertex.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0 <= '0;
      row1 <= '0;
      row2 <= '0;
      row3 <= Row3Reset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRow0: row0 <= cfg_data;
        RegRow1: row1 <= cfg_data;
        RegRow2: row2 <= cfg_data;
        RegRow3: row3 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Latency-2:0], vertex.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wz <= {wz[DivLat-2:0], tw == '0};
    end
  end

  vtp_mult u_mult (
    .clk(clk), .en(en), .row0(row0), .row1(row1), .row3(row3),
    .vx(vertex.vertex_x), .vy(vertex.vertex_y), .vz(vertex.vertex_z),
    .tx(tx), .ty(ty), .tw(tw)
  );

  coord_t qx, qy;

  vtp_div u_div_x (.clk(clk), .en(en), .num(tx), .den(tw), .quo(qx));
  vtp_div u_div_y (.clk(clk), .en(en), .num(ty), .den(tw), .quo(qy));

  logic row2_unused;
  assign row2_unused = ^row2;

  assign screen.valid    = vld[Latency-1];
  assign screen.w_zero   = wz[DivLat-1] | (row2_unused & 1'b0);
  assign screen.screen_x = wz[DivLat-1] ? '0 : qx;
  assign screen.screen_y = wz[DivLat-1] ? '0 : qy;
endmodule

/* rtl/vtp_check.sv */
`timescale 1ns / 1ps
module vtp_check (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input vtp_pkg::coord_t        screen_x,
  input vtp_pkg::coord_t        screen_y,
  input logic                   w_zero
);
  a_zero_coords: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero |-> screen_x == '0 && screen_y == '0)
    else $error("w_zero with nonzero coordinates");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y)
      && $stable(w_zero))
    else $error("stalled item changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
endmodule

bind vertex_transform_perspective_divide vtp_check u_vtp_check (
  .clk(clk), .rst(rst),
  .in_ready(vertex.ready),
  .out_valid(screen.valid), .out_ready(screen.ready),
  .screen_x(screen.screen_x), .screen_y(screen.screen_y), .w_zero(screen.w_zero)
);
